[design/ssr_pkg.sv]
// ssr_pkg: shared constants, register codes and the job control type for the stream
// substring replacer. No dependencies.
package ssr_pkg;

    localparam int MAX_PATTERN_DEF = 8;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_INDEX_W     = 2;
    localparam int LEN_W           = 4;
    localparam int COUNT_W         = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_FIND_PATTERN    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FIND_LENGTH     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_REPLACE_PATTERN = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_REPLACE_LENGTH  = 2'd3;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Control part of one emit job handed from the front to the back.
    typedef struct packed {
        logic               is_end;
        logic [COUNT_W-1:0] tally;
    } job_ctl_t;

endpackage

[design/ssr_front.sv]
// ssr_front: configuration registers, pending byte window and pattern compare.
// Turns each accepted byte into at most one emit job. Depends on ssr_pkg.
module ssr_front #(
    parameter int MAX_PATTERN = ssr_pkg::MAX_PATTERN_DEF,
    parameter int LW          = $clog2(MAX_PATTERN + 1)
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [ssr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ssr_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               push,
    input  logic [7:0]                         byte_in,
    input  logic                               last_in,
    input  logic                               q_full,
    output logic                               job_push,
    output logic [MAX_PATTERN*8-1:0]           job_bytes,
    output logic [LW-1:0]                      job_cnt,
    output ssr_pkg::job_ctl_t                  job_ctl
);

    localparam logic [ssr_pkg::LEN_W-1:0] MP_LEN = MAX_PATTERN[ssr_pkg::LEN_W-1:0];

    logic [ssr_pkg::CFG_DATA_W-1:0] find_pattern_reg;
    logic [ssr_pkg::LEN_W-1:0]      find_len_reg;
    logic [ssr_pkg::CFG_DATA_W-1:0] replace_pattern_reg;
    logic [ssr_pkg::LEN_W-1:0]      replace_len_reg;

    logic [MAX_PATTERN-1:0][7:0]    win_reg, win_next;
    logic [LW-1:0]                  fill_reg, fill_next;
    logic [ssr_pkg::COUNT_W-1:0]    tally_reg, tally_next;

    logic [LW-1:0]                  flen, rlen, fill_inc;
    logic [MAX_PATTERN-1:0][7:0]    win_ins;
    logic                           accept, full_win, match;
    logic [ssr_pkg::COUNT_W-1:0]    tally_inc;

    assign flen = (find_len_reg == '0) ? LW'(1) :
                  (find_len_reg > MP_LEN) ? LW'(MAX_PATTERN) : find_len_reg[LW-1:0];
    assign rlen = (replace_len_reg > MP_LEN) ? LW'(MAX_PATTERN) : replace_len_reg[LW-1:0];

    assign accept   = push && !q_full;
    assign fill_inc = fill_reg + LW'(1);
    assign full_win = (fill_inc == flen);

    always_comb
    begin
        win_ins = win_reg;
        match   = 1'b1;
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            if (LW'(k) == fill_reg)
                win_ins[k] = byte_in;
        end
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            if (LW'(k) < flen && win_ins[k] != find_pattern_reg[8*k +: 8])
                match = 1'b0;
        end
    end

    assign tally_inc = (full_win && match && tally_reg != ssr_pkg::COUNT_MAX) ?
                       tally_reg + 1'b1 : tally_reg;

    // job: replacement bytes on a hit, else the oldest byte, or the whole
    // window when the string ends here; a deleting hit mid-string makes none
    always_comb
    begin
        job_push       = accept && (last_in || (full_win && !(match && rlen == '0)));
        job_ctl.is_end = last_in;
        job_ctl.tally  = tally_inc;
        if (full_win && match)
        begin
            job_bytes = replace_pattern_reg[MAX_PATTERN*8-1:0];
            job_cnt   = rlen;
        end
        else
        begin
            job_bytes = win_ins;
            if (full_win)
                job_cnt = last_in ? flen : LW'(1);
            else
                job_cnt = fill_inc;
        end
    end

    always_comb
    begin
        win_next   = win_ins;
        fill_next  = fill_reg;
        tally_next = tally_reg;
        if (cfg_write)
        begin
            if (cfg_index == ssr_pkg::REG_FIND_LENGTH)
                fill_next = '0;
        end
        else if (accept)
        begin
            if (last_in)
            begin
                fill_next  = '0;
                tally_next = '0;
            end
            else if (full_win && match)
            begin
                fill_next  = '0;
                tally_next = tally_inc;
            end
            else if (full_win)
            begin
                // drop the oldest byte, fill stays at flen - 1
                for (int k = 0; k < MAX_PATTERN - 1; k++)
                    win_next[k] = win_ins[k+1];
            end
            else
            begin
                fill_next = fill_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            find_pattern_reg    <= '0;
            find_len_reg        <= ssr_pkg::LEN_W'(1);
            replace_pattern_reg <= '0;
            replace_len_reg     <= '0;
            win_reg             <= '0;
            fill_reg            <= '0;
            tally_reg           <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    ssr_pkg::REG_FIND_PATTERN:    find_pattern_reg    <= cfg_data;
                    ssr_pkg::REG_FIND_LENGTH:
                        find_len_reg <= cfg_data[ssr_pkg::LEN_W-1:0];
                    ssr_pkg::REG_REPLACE_PATTERN: replace_pattern_reg <= cfg_data;
                    ssr_pkg::REG_REPLACE_LENGTH:
                        replace_len_reg <= cfg_data[ssr_pkg::LEN_W-1:0];
                    default: ;
                endcase
            end
            win_reg   <= win_next;
            fill_reg  <= fill_next;
            tally_reg <= tally_next;
        end
    end

    // window never holds a full pattern between bytes
    a_fill_below_len: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg < flen)
        else $error("window fill reached find length");

    a_tally_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        $past(tally_reg) == ssr_pkg::COUNT_MAX && tally_reg != '0 |->
            tally_reg == ssr_pkg::COUNT_MAX)
        else $error("replacement tally wrapped");

endmodule

[design/ssr_queue.sv]
// ssr_queue: short register queue of emit jobs between front and back.
// Depends on ssr_pkg.
module ssr_queue #(
    parameter int W     = 8,
    parameter int DEPTH = ssr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] din,
    output logic         full,
    input  logic         pop,
    output logic         valid,
    output logic [W-1:0] dout
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DEPTH-1:0][W-1:0] slot_reg;
    logic [PW-1:0]           wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]           count_reg, count_next;

    assign full  = (count_reg == CW'(DEPTH));
    assign valid = (count_reg != '0);
    assign dout  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + CW'(1);
        else if (pop && !push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= din;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            count_reg <= count_next;
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("job pushed into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> valid)
        else $error("job popped from empty queue");

endmodule

[design/ssr_back.sv]
// ssr_back: expands emit jobs into result items, one per cycle while pop is high.
// Depends on ssr_pkg.
module ssr_back #(
    parameter int MAX_PATTERN = ssr_pkg::MAX_PATTERN_DEF,
    parameter int LW          = $clog2(MAX_PATTERN + 1)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_valid,
    input  logic [MAX_PATTERN*8-1:0]        q_bytes,
    input  logic [LW-1:0]                   q_cnt,
    input  ssr_pkg::job_ctl_t               q_ctl,
    output logic                            q_pop,
    output logic                            empty,
    input  logic                            pop,
    output logic [7:0]                      byte_out,
    output logic                            byte_valid,
    output logic                            end_of_string,
    output logic [ssr_pkg::COUNT_W-1:0]     replacement_count,
    output logic                            last_of_run
);

    logic                         cur_valid_reg;
    logic [MAX_PATTERN-1:0][7:0]  cur_bytes_reg;
    logic [LW-1:0]                cur_cnt_reg;
    ssr_pkg::job_ctl_t            cur_ctl_reg;
    logic [LW-1:0]                pos_reg;
    logic [7:0]                   sel_byte;
    logic                         transfer;

    assign empty      = !cur_valid_reg;
    assign transfer   = pop && cur_valid_reg;
    assign byte_valid = (pos_reg < cur_cnt_reg);

    assign last_of_run = cur_ctl_reg.is_end ? (pos_reg == cur_cnt_reg) :
                         ({1'b0, pos_reg} + 1'b1 == {1'b0, cur_cnt_reg});

    always_comb
    begin
        sel_byte = '0;
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            if (LW'(k) == pos_reg)
                sel_byte = cur_bytes_reg[k];
        end
    end

    assign byte_out          = byte_valid ? sel_byte : 8'd0;
    assign end_of_string     = !byte_valid;
    assign replacement_count = byte_valid ? '0 : cur_ctl_reg.tally;

    assign q_pop = q_valid && (!cur_valid_reg || (transfer && last_of_run));

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_bytes_reg <= q_bytes;
            cur_cnt_reg   <= q_cnt;
            cur_ctl_reg   <= q_ctl;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            pos_reg       <= '0;
        end
        else
        begin
            if (q_pop)
            begin
                cur_valid_reg <= 1'b1;
                pos_reg       <= '0;
            end
            else if (transfer)
            begin
                if (last_of_run)
                    cur_valid_reg <= 1'b0;
                else
                    pos_reg <= pos_reg + LW'(1);
            end
        end
    end

    a_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && end_of_string |-> last_of_run && cur_ctl_reg.is_end)
        else $error("end item not at close of run");

    a_pos_in_job: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> pos_reg <= cur_cnt_reg)
        else $error("result position past job length");

endmodule

[design/stream_substring_replacer_unit.sv]
// stream_substring_replacer_unit: streaming find-and-replace, top level.
// Instantiates ssr_front, ssr_queue and ssr_back; depends on ssr_pkg.
//
//   channel   handshake            payload
//   config    cfg_write            cfg_index, cfg_data
//   input     push / full          byte_in, last_in
//   result    empty / pop          byte_out, byte_valid, end_of_string,
//                                  replacement_count, last_of_run
//
// One byte accepted per cycle while full is low; a byte yields up to
// MAX_PATTERN + 1 results, one result per cycle while pop is high.
// A byte's first result passes through the job queue and the ssr_back job register.
// full rises when the job queue between compare and emit (QUEUE_DEPTH deep) fills.
// Reset clears the window, tally and queue and loads the default lengths.
module stream_substring_replacer_unit #(
    parameter int MAX_PATTERN = ssr_pkg::MAX_PATTERN_DEF,
    parameter int QUEUE_DEPTH = ssr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [ssr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ssr_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            push,
    output logic                            full,
    input  logic [7:0]                      byte_in,
    input  logic                            last_in,
    output logic                            empty,
    input  logic                            pop,
    output logic [7:0]                      byte_out,
    output logic                            byte_valid,
    output logic                            end_of_string,
    output logic [ssr_pkg::COUNT_W-1:0]     replacement_count,
    output logic                            last_of_run
);

    localparam int LW    = $clog2(MAX_PATTERN + 1);
    localparam int CTL_W = $bits(ssr_pkg::job_ctl_t);
    localparam int JOB_W = MAX_PATTERN * 8 + LW + CTL_W;

    logic                       job_push, q_valid, q_pop;
    logic [MAX_PATTERN*8-1:0]   job_bytes, q_bytes;
    logic [LW-1:0]              job_cnt, q_cnt;
    ssr_pkg::job_ctl_t          job_ctl, q_ctl;
    logic [JOB_W-1:0]           q_dout;

    ssr_front #(
        .MAX_PATTERN (MAX_PATTERN),
        .LW          (LW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .byte_in   (byte_in),
        .last_in   (last_in),
        .q_full    (full),
        .job_push  (job_push),
        .job_bytes (job_bytes),
        .job_cnt   (job_cnt),
        .job_ctl   (job_ctl)
    );

    ssr_queue #(
        .W     (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_push),
        .din   ({job_bytes, job_cnt, job_ctl}),
        .full  (full),
        .pop   (q_pop),
        .valid (q_valid),
        .dout  (q_dout)
    );

    assign q_bytes = q_dout[JOB_W-1 -: MAX_PATTERN*8];
    assign q_cnt   = q_dout[CTL_W +: LW];
    assign q_ctl   = q_dout[CTL_W-1:0];

    ssr_back #(
        .MAX_PATTERN (MAX_PATTERN),
        .LW          (LW)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .q_valid           (q_valid),
        .q_bytes           (q_bytes),
        .q_cnt             (q_cnt),
        .q_ctl             (q_ctl),
        .q_pop             (q_pop),
        .empty             (empty),
        .pop               (pop),
        .byte_out          (byte_out),
        .byte_valid        (byte_valid),
        .end_of_string     (end_of_string),
        .replacement_count (replacement_count),
        .last_of_run       (last_of_run)
    );

endmodule

[tb/ssr_result_checker.sv]
// ssr_result_checker: scoreboard for stream_substring_replacer_unit. It predicts
// the result stream from observed config writes and input transfers and compares
// every result transfer. Depends on ssr_pkg.
module ssr_result_checker
    import ssr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   push,
    input  logic                   full,
    input  logic [7:0]             byte_in,
    input  logic                   last_in,
    input  logic                   empty,
    input  logic                   pop,
    input  logic [7:0]             byte_out,
    input  logic                   byte_valid,
    input  logic                   end_of_string,
    input  logic [COUNT_W-1:0]     replacement_count,
    input  logic                   last_of_run,
    output int                     mismatches,
    output int                     outstanding,
    output int                     results_seen,
    output int                     strings_seen,
    output int                     replacements
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0]         data;
        logic               valid;
        logic               eos;
        logic [COUNT_W-1:0] count;
        logic               last;
    } out_rec_t;

    localparam int WIN_MAX = MAX_PATTERN_DEF;

    logic [CFG_DATA_W-1:0] find_q;
    logic [CFG_DATA_W-1:0] repl_q;
    logic [LEN_W-1:0]      flen_q;
    logic [LEN_W-1:0]      rlen_q;
    logic [7:0]            win [WIN_MAX];
    int                    fill;
    int                    tally;
    out_rec_t              pending_out [$];

    function automatic logic [7:0] take_oldest();
        logic [7:0] b;
        b = win[0];
        for (int i = 1; i < fill; i++)
            win[i-1] = win[i];
        if (fill > 0)
            fill--;
        return b;
    endfunction

    function automatic void queue_byte(input logic [7:0] b);
        pending_out.push_back('{data: b, valid: 1'b1, eos: 1'b0, count: '0, last: 1'b0});
    endfunction

    // Expected results of one accepted byte; last_of_run set on the final one.
    task automatic predict_bytes(input logic [7:0] b, input logic lst);
        int  flen;
        int  rlen;
        int  first;
        bit  hit;
        flen  = (flen_q == 0) ? 1 : ((flen_q > WIN_MAX) ? WIN_MAX : int'(flen_q));
        rlen  = (rlen_q > WIN_MAX) ? WIN_MAX : int'(rlen_q);
        first = pending_out.size();
        if (fill < WIN_MAX && fill < flen)
        begin
            win[fill] = b;
            fill++;
        end
        if (fill >= flen)
        begin
            hit = 1'b1;
            for (int k = 0; k < flen; k++)
                if (win[k] != find_q[8*k +: 8])
                    hit = 1'b0;
            if (hit)
            begin
                for (int k = 0; k < rlen; k++)
                    queue_byte(repl_q[8*k +: 8]);
                fill = 0;
                replacements++;
                if (tally < 65535)
                    tally++;
            end
            else
            begin
                queue_byte(take_oldest());
            end
        end
        if (lst)
        begin
            while (fill > 0)
                queue_byte(take_oldest());
            pending_out.push_back('{data: 8'h00, valid: 1'b0, eos: 1'b1,
                                    count: COUNT_W'(tally), last: 1'b0});
            tally = 0;
            fill  = 0;
        end
        if (pending_out.size() > first)
            pending_out[pending_out.size()-1].last = 1'b1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        out_rec_t got;
        out_rec_t want;
        if (!rst_n)
        begin
            find_q  = '0;
            flen_q  = LEN_W'(1);
            repl_q  = '0;
            rlen_q  = '0;
            foreach (win[i])
                win[i] = '0;
            fill    = 0;
            tally   = 0;
            pending_out.delete();
            mismatches   = 0;
            results_seen = 0;
            strings_seen = 0;
            replacements = 0;
            outstanding <= 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                got = '{data: byte_out, valid: byte_valid, eos: end_of_string,
                        count: replacement_count, last: last_of_run};
                results_seen++;
                if (got.eos)
                    strings_seen++;
                if (pending_out.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: extra result byte %02h valid %b eos %b count %0d last %b",
                                 $realtime, got.data, got.valid, got.eos, got.count, got.last);
                end
                else
                begin
                    want = pending_out.pop_front();
                    if (got.data !== want.data || got.valid !== want.valid ||
                        got.eos !== want.eos || got.count !== want.count ||
                        got.last !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("%0t: expected byte %02h valid %b eos %b count %0d last %b",
                                     $realtime, want.data, want.valid, want.eos, want.count,
                                     want.last);
                            $display("%0t: got      byte %02h valid %b eos %b count %0d last %b",
                                     $realtime, got.data, got.valid, got.eos, got.count,
                                     got.last);
                        end
                    end
                end
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_FIND_PATTERN:    find_q = cfg_data;
                    REG_FIND_LENGTH:
                    begin
                        flen_q = cfg_data[LEN_W-1:0];
                        fill   = 0;   // pending window dropped, tally kept
                    end
                    REG_REPLACE_PATTERN: repl_q = cfg_data;
                    REG_REPLACE_LENGTH:  rlen_q = cfg_data[LEN_W-1:0];
                    default: ;
                endcase
            end
            if (push && !full)
                predict_bytes(byte_in, last_in);
            outstanding <= pending_out.size();
        end
    end

endmodule

[tb/tb_stream_substring_replacer_unit.sv]
// tb_stream_substring_replacer_unit: stimulus and verdict for the streaming
// find-and-replace unit. Instantiates the unit and ssr_result_checker; uses ssr_pkg.
module tb_stream_substring_replacer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import ssr_pkg::*;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   push      = 1'b0;
    logic [7:0]             byte_in   = '0;
    logic                   last_in   = 1'b0;
    logic                   pop       = 1'b0;
    logic                   full;
    logic                   empty;
    logic [7:0]             byte_out;
    logic                   byte_valid;
    logic                   end_of_string;
    logic [COUNT_W-1:0]     replacement_count;
    logic                   last_of_run;

    int mismatches;
    int outstanding;
    int results_seen;
    int strings_seen;
    int replacements;

    int idle_pct   = 0;
    int stall_pct  = 0;
    int bytes_sent = 0;
    int settings   = 0;

    logic [CFG_DATA_W-1:0] find_cfg = '0;
    int                    flen_eff = 1;

    stream_substring_replacer_unit dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .push              (push),
        .full              (full),
        .byte_in           (byte_in),
        .last_in           (last_in),
        .empty             (empty),
        .pop               (pop),
        .byte_out          (byte_out),
        .byte_valid        (byte_valid),
        .end_of_string     (end_of_string),
        .replacement_count (replacement_count),
        .last_of_run       (last_of_run)
    );

    ssr_result_checker u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .push              (push),
        .full              (full),
        .byte_in           (byte_in),
        .last_in           (last_in),
        .empty             (empty),
        .pop               (pop),
        .byte_out          (byte_out),
        .byte_valid        (byte_valid),
        .end_of_string     (end_of_string),
        .replacement_count (replacement_count),
        .last_of_run       (last_of_run),
        .mismatches        (mismatches),
        .outstanding       (outstanding),
        .results_seen      (results_seen),
        .strings_seen      (strings_seen),
        .replacements      (replacements)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver side: random stall per cycle
    always @(posedge clk)
        pop <= ($urandom_range(99) >= stall_pct);

    initial
    begin
        #10_000_000;
        $display("stream_substring_replacer_unit verification failed");
        $finish;
    end

    task automatic cfg_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    // Hold the sender until every expected result is out, then let the
    // pipeline empty of bytes that produce nothing.
    task automatic settle();
        push <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] fp, input int fl,
                              input logic [CFG_DATA_W-1:0] rp, input int rl);
        logic [CFG_DATA_W-1:0] noise;
        settle();
        cfg_reg(REG_FIND_PATTERN, fp);
        noise      = {$urandom, $urandom};
        noise[3:0] = 4'(fl);
        cfg_reg(REG_FIND_LENGTH, noise);
        cfg_reg(REG_REPLACE_PATTERN, rp);
        noise      = {$urandom, $urandom};
        noise[3:0] = 4'(rl);
        cfg_reg(REG_REPLACE_LENGTH, noise);
        cfg_write <= 1'b0;
        find_cfg = fp;
        flen_eff = (fl == 0) ? 1 : ((fl > 8) ? 8 : fl);
        settings++;
    endtask

    task automatic send(input logic [7:0] b, input logic lst);
        while ($urandom_range(99) < idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push    <= 1'b1;
        byte_in <= b;
        last_in <= lst;
        @(posedge clk);
        while (full)
            @(posedge clk);
        bytes_sent++;
    endtask

    function automatic logic [CFG_DATA_W-1:0] make_pattern(input bit narrow);
        logic [CFG_DATA_W-1:0] p;
        for (int i = 0; i < 8; i++)
            p[8*i +: 8] = narrow ? ($urandom_range(1) ? 8'h61 : 8'h62) : 8'($urandom_range(255));
        return p;
    endfunction

    // Nearly half are bytes of the find pattern so partial and overlapping matches occur.
    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(99);
        if (r < 45)
            return find_cfg[8*$urandom_range(flen_eff-1) +: 8];
        else if (r < 55)
            return $urandom_range(1) ? 8'hFF : 8'h00;
        else
            return 8'($urandom_range(255));
    endfunction

    initial
    begin
        int sent;
        bit paused;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: one-byte pattern 00 deleted
        send(8'h00, 1'b0);
        send(8'hFF, 1'b0);
        send(8'h55, 1'b1);

        set_config(64'h4241, 2, 64'h7A7978, 3);
        send(8'h41, 1'b0);
        send(8'h42, 1'b0);
        send(8'h41, 1'b0);
        send(8'h41, 1'b0);
        send(8'h42, 1'b0);
        send(8'h42, 1'b0);
        send(8'h41, 1'b1);

        // widest case: full-length match followed by end item in one byte
        set_config('1, 8, 64'h0123_4567_89AB_CDEF, 8);
        repeat (7) send(8'hFF, 1'b0);
        send(8'hFF, 1'b1);

        // find length rewritten while bytes are pending
        set_config(make_pattern(0), 3, make_pattern(0), 2);
        send(8'h10, 1'b0);
        send(8'h11, 1'b0);
        settle();
        cfg_reg(REG_FIND_LENGTH, 64'd3);
        cfg_write <= 1'b0;
        send(8'h12, 1'b1);

        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0: set_config(make_pattern(0), 1, make_pattern(0), 1);
                1: set_config(make_pattern(1), 8, make_pattern(0), 8);
                2: set_config(make_pattern(0), 0, make_pattern(0), 8);
                3: set_config(make_pattern(1), 15, make_pattern(0), 12);
                4: set_config(make_pattern(1), 2, make_pattern(0), 0);
                5: set_config('0, 3, '1, 5);
                6: set_config('1, 8, make_pattern(0), 0);
                default: set_config(make_pattern(1), $urandom_range(8, 1), make_pattern(0),
                                    $urandom_range(8));
            endcase
            idle_pct  = (p % 4 == 1) ? 84 : ((p % 4 == 3) ? 18 : 0);
            stall_pct = (p % 4 == 2) ? 84 : ((p % 4 == 3) ? 18 : 0);
            sent   = 0;
            paused = 1'b0;
            while (sent < 62)
            begin
                if (!paused && sent >= 31)
                begin
                    settle();
                    paused = 1'b1;
                end
                if ($urandom_range(99) < 30)
                begin
                    for (int k = 0; k < flen_eff; k++)
                        send(find_cfg[8*k +: 8],
                             (k == flen_eff - 1) && ($urandom_range(99) < 15));
                    sent += flen_eff;
                end
                else
                begin
                    send(pick_byte(), $urandom_range(99) < 8);
                    sent++;
                end
            end
        end
        send(pick_byte(), 1'b1);
        settle();

        $display("covered %0d bytes in, %0d results checked, %0d strings, %0d replacements",
                 bytes_sent, results_seen, strings_seen, replacements);
        $display("over %0d register settings and four idle/stall mixes", settings);
        if (mismatches == 0 && outstanding == 0)
            $display("stream_substring_replacer_unit verification clean");
        else
            $display("stream_substring_replacer_unit verification failed");
        $finish;
    end

endmodule
